// ===== rtl/core/cfc_pkg.sv =====
// Chain frame receive checker: shared constants, codes and types.
// No dependencies; imported by the modules of the block and the testbench.
`default_nettype none

package cfc_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 1024;

  localparam int HEADER_BYTES = 17;
  localparam int SUM_W        = 25;  // 782 bytes max in the span, 391 words
  localparam int SPAN_W       = 10;  // 17 + 3*255 + 2 fits

  localparam int POS_TYPE_LO = 12;
  localparam int POS_TYPE_HI = 13;
  localparam int POS_INDEX   = 14;
  localparam int POS_KIND    = 15;
  localparam int POS_COUNT   = 16;
  localparam int POS_ID      = 17;
  localparam int POS_FLAGS   = 18;

  localparam logic [7:0] KIND_BCAST     = 8'h01;
  localparam logic [7:0] KIND_BCAST_ACK = 8'h81;
  localparam logic [7:0] KIND_HEART     = 8'h02;
  localparam logic [7:0] KIND_HEART_ACK = 8'h82;

  localparam logic [15:0] ETHER_TYPE_RESET = 16'h88AE;

  localparam logic REG_CHECKSUM_ENABLE = 1'b0;
  localparam logic REG_ETHER_TYPE      = 1'b1;

  typedef enum logic [2:0] {
    CLS_BAD_SUM    = 3'd0,
    CLS_WRONG_TYPE = 3'd1,
    CLS_BCAST      = 3'd2,
    CLS_BCAST_ACK  = 3'd3,
    CLS_HEART      = 3'd4,
    CLS_HEART_ACK  = 3'd5,
    CLS_OTHER      = 3'd6,
    CLS_SHORT      = 3'd7
  } frame_class_t;

  // Everything kept from a finished frame but its length.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [15:0]      rsum;
    logic [7:0]       index;
    logic [7:0]       count;
    logic [7:0]       kind;
    logic [7:0]       id;
    logic [7:0]       flags;
    logic             tmatch;
    logic             cen;
  } frame_snap_t;

  typedef struct packed {
    frame_class_t cls;
    logic [7:0]   index;
    logic [7:0]   count;
    logic [7:0]   id;
    logic         up;
    logic         down;
  } frame_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/cfc_rx_if.sv =====
// Byte channel into the chain frame receive checker: valid/ready plus payload.
// Depends on nothing.
`default_nettype none

interface cfc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cfc_res_if.sv =====
// Result channel out of the chain frame receive checker: valid/ready plus payload.
// Depends on nothing.
`default_nettype none

interface cfc_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] frame_class;
  logic [7:0] board_index;
  logic [7:0] entry_count;
  logic [7:0] device_id;
  logic       device_up;
  logic       device_down;

  modport source (output valid, output frame_class, output board_index,
                  output entry_count, output device_id, output device_up,
                  output device_down, input ready);
  modport sink   (input valid, input frame_class, input board_index,
                  input entry_count, input device_id, input device_up,
                  input device_down, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/chain_frame_receive_checker.sv =====
// Channel | dir | payload                                        | accepted when
// rx      | in  | frame_byte[7:0], last_byte                      | valid & ready
// res     | out | frame_class, board_index, entry_count,          | valid & ready
//         |     | device_id, device_up, device_down               |
// apb     | in  | checksum_enable at 0x0, ether_type at 0x4       | psel & penable & pwrite
//
// One byte a cycle while rx is not stalled. The running sum, position and
// header captures update on accepted beats below the frame limit; the closing
// beat loads a snapshot slot and the result register loads from the classify
// stage when the snapshot advances, which waits while a held result is not
// taken. rx stalls only while the snapshot slot and the result register both
// hold a frame and res.ready is low. Synchronous reset clears the frame state
// and both slots and restores the register defaults.
// Depends on cfc_pkg, cfc_rx_if, cfc_res_if and cfc_classify.
`default_nettype none

module chain_frame_receive_checker
  import cfc_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cfc_rx_if.sink      rx,
  cfc_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CMP_W = (POS_W > SPAN_W) ? POS_W : SPAN_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

  // configuration
  logic        cen;
  logic [15:0] ether_type;

  // frame state
  logic [POS_W-1:0] pos,  pos_next;
  logic [SUM_W-1:0] sum,  sum_next;
  logic [15:0]      rsum, rsum_next;
  logic [7:0]       tlow, tlow_next;
  logic             tmatch, tmatch_next;
  logic [7:0]       kind, kind_next;
  logic [7:0]       index, index_next;
  logic [7:0]       count, count_next;
  logic [7:0]       id, id_next;
  logic [7:0]       flags, flags_next;

  logic             take;
  logic [SPAN_W-1:0] span;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] span_x;
  logic [SUM_W-1:0] addend;

  // pipeline
  logic             rx_fire;
  logic             snap_valid;
  logic             snap_adv;
  logic             res_valid;
  frame_snap_t      snap;
  logic [POS_W-1:0] snap_len;
  frame_res_t       cls_res;
  frame_res_t       res_q;

  // APB
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cen        <= 1'b1;
      ether_type <= ETHER_TYPE_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_CHECKSUM_ENABLE: cen        <= pwdata[0];
        REG_ETHER_TYPE:      ether_type <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CHECKSUM_ENABLE: prdata = {31'b0, cen};
      REG_ETHER_TYPE:      prdata = {16'b0, ether_type};
      default:             prdata = '0;
    endcase
  end

  // handshake
  assign rx_fire  = rx.valid && rx.ready;
  assign snap_adv = snap_valid && (!res_valid || res.ready);
  assign rx.ready = !snap_valid || snap_adv;

  // per-beat update
  always_comb begin
    take   = pos < POS_MAX;
    span   = SPAN_W'(HEADER_BYTES) + SPAN_W'({count, 1'b0}) + SPAN_W'(count);
    pos_x  = CMP_W'(pos);
    span_x = CMP_W'(span);
    addend = pos[0] ? SUM_W'(rx.frame_byte) : SUM_W'({rx.frame_byte, 8'h00});

    pos_next    = pos;
    sum_next    = sum;
    rsum_next   = rsum;
    tlow_next   = tlow;
    tmatch_next = tmatch;
    kind_next   = kind;
    index_next  = index;
    count_next  = count;
    id_next     = id;
    flags_next  = flags;

    if (take) begin
      pos_next = pos + POS_W'(1);
      if (pos_x < span_x) begin
        sum_next = sum + addend;
      end
      if (pos_x == span_x) begin
        rsum_next[7:0] = rx.frame_byte;
      end
      if (pos_x == span_x + CMP_W'(1)) begin
        rsum_next[15:8] = rx.frame_byte;
      end
      if (pos == POS_W'(POS_TYPE_LO)) tlow_next   = rx.frame_byte;
      if (pos == POS_W'(POS_TYPE_HI)) tmatch_next = ({rx.frame_byte, tlow} == ether_type);
      if (pos == POS_W'(POS_INDEX))   index_next  = rx.frame_byte;
      if (pos == POS_W'(POS_KIND))    kind_next   = rx.frame_byte;
      if (pos == POS_W'(POS_COUNT))   count_next  = rx.frame_byte;
      if (pos == POS_W'(POS_ID))      id_next     = rx.frame_byte;
      if (pos == POS_W'(POS_FLAGS))   flags_next  = rx.frame_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (rx_fire && rx.last_byte)) begin
      pos    <= '0;
      sum    <= '0;
      rsum   <= '0;
      tlow   <= '0;
      tmatch <= 1'b0;
      kind   <= '0;
      index  <= '0;
      count  <= '0;
      id     <= '0;
      flags  <= '0;
    end else if (rx_fire) begin
      pos    <= pos_next;
      sum    <= sum_next;
      rsum   <= rsum_next;
      tlow   <= tlow_next;
      tmatch <= tmatch_next;
      kind   <= kind_next;
      index  <= index_next;
      count  <= count_next;
      id     <= id_next;
      flags  <= flags_next;
    end
  end

  // snapshot slot
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (rx_fire && rx.last_byte) begin
      snap_valid <= 1'b1;
    end else if (snap_adv) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_fire && rx.last_byte) begin
      snap.sum    <= sum_next;
      snap.rsum   <= rsum_next;
      snap.index  <= index_next;
      snap.count  <= count_next;
      snap.kind   <= kind_next;
      snap.id     <= id_next;
      snap.flags  <= flags_next;
      snap.tmatch <= tmatch_next;
      snap.cen    <= cen;
      snap_len    <= pos_next;
    end
  end

  cfc_classify #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_classify (
    .snap (snap),
    .len  (snap_len),
    .res  (cls_res)
  );

  // result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (snap_adv) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_adv) begin
      res_q <= cls_res;
    end
  end

  assign res.valid       = res_valid;
  assign res.frame_class = res_q.cls;
  assign res.board_index = res_q.index;
  assign res.entry_count = res_q.count;
  assign res.device_id   = res_q.id;
  assign res.device_up   = res_q.up;
  assign res.device_down = res_q.down;

`ifndef NO_ASSERTIONS
  // rx only stalls behind a blocked snapshot
  a_rx_stall: assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> (snap_valid && res_valid && !res.ready))
    else $error("rx stalled without a blocked result");

  // a closing beat always lands in the snapshot slot
  a_snap_load: assert property (@(posedge clk) disable iff (rst)
    (rx_fire && rx.last_byte) |=> snap_valid)
    else $error("closing beat lost");

  // frame state restarts after the closing beat
  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (rx_fire && rx.last_byte) |=> (pos == '0 && sum == '0 && count == '0))
    else $error("frame state not cleared");

  // position saturates at the frame limit
  a_pos_limit: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_MAX)
    else $error("byte position past limit");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/cfc_classify.sv =====
// Frame classifier: folds the checksum, checks length and type, decodes the kind.
// Depends on cfc_pkg.
`default_nettype none

module cfc_classify
  import cfc_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  frame_snap_t                              snap,
  input  logic [$clog2(MAX_FRAME_BYTES + 1)-1:0]   len,
  output frame_res_t                               res
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CMP_W = (POS_W > SPAN_W) ? POS_W : SPAN_W;

  logic [16:0]      fold1;
  logic [16:0]      fold2;
  logic [15:0]      check;
  logic [CMP_W-1:0] need;
  logic             short_frame;

  always_comb begin
    fold1 = {8'b0, snap.sum[SUM_W-1:16]} + {1'b0, snap.sum[15:0]};
    fold2 = {16'b0, fold1[16]} + {1'b0, fold1[15:0]};
    check = ~fold2[15:0];

    if (snap.cen) begin
      need = CMP_W'(HEADER_BYTES + 2) + CMP_W'({snap.count, 1'b0}) + CMP_W'(snap.count);
    end else begin
      need = CMP_W'(HEADER_BYTES);
    end
    short_frame = CMP_W'(len) < need;

    res = '0;
    if (short_frame) begin
      res.cls = CLS_SHORT;
    end else if (snap.cen && (check != snap.rsum)) begin
      res.cls = CLS_BAD_SUM;
    end else if (!snap.tmatch) begin
      res.cls = CLS_WRONG_TYPE;
    end else begin
      res.index = snap.index;
      res.count = snap.count;
      case (snap.kind)
        KIND_BCAST: begin
          res.cls  = CLS_BCAST;
          res.id   = snap.id;
          res.up   = snap.flags[0];
          res.down = snap.flags[1];
        end
        KIND_BCAST_ACK: res.cls = CLS_BCAST_ACK;
        KIND_HEART:     res.cls = CLS_HEART;
        KIND_HEART_ACK: res.cls = CLS_HEART_ACK;
        default:        res.cls = CLS_OTHER;
      endcase
    end
  end

endmodule

`default_nettype wire
